// File: sv/wmsd_pkg.sv
// Shared types and constants for the windowed mean / standard deviation unit.
// No dependencies.
package wmsd_pkg;

  localparam int unsigned MaxSamplesDef = 1024;

  localparam int unsigned StartW = 10;
  localparam int unsigned LenW   = 11;
  localparam int unsigned CfgW   = 11;
  localparam int unsigned CfgIdxW = 2;

  // sum of up to 1024 signed 32-bit words
  localparam int unsigned SumW = 32 + LenW;
  // sum of up to 1024 squares below 2^65
  localparam int unsigned AccW = 64 + LenW;
  localparam int unsigned DivW = AccW;
  localparam int unsigned IterW = $clog2(DivW + 1);

  localparam logic [CfgIdxW-1:0] CfgWinStart = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgWinLen   = 2'd1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SUM,
    S_MDIV,
    S_SQR,
    S_VDIV,
    S_ROOT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic signed [31:0] sample;
    logic               last_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] mean;
    logic [31:0]        std_dev;
    logic               window_valid;
    logic               store_overflow;
  } out_word_t;

endpackage

// File: sv/windowed_mean_std_dev_unit.sv
// Top level of the windowed mean / standard deviation unit: sample store,
// sequencer, shared shift-subtract divider and bit-serial square root.
// Depends on wmsd_pkg.

// Samples load at one word per cycle while busy_o is low: a word without
// last_sample is taken, written to the store unless it is full (then
// store_overflow is flagged), and busy_o stays low. A word with last_sample is
// stored likewise and starts the computation; busy_o stays high through the
// done state, which carries the result strobe. The sequence is a check state,
// two passes over the window through the single store read port, two 75-bit
// radix-2 divisions on one shared divider, a square root and the done state.
// An empty or out-of-range window goes from the check state straight to done.
// result_valid_o is high for exactly one cycle and is not held; the receiver must
// take it then. Configuration writes land immediately and should only happen
// while busy_o is low.
module windowed_mean_std_dev_unit #(
  parameter int unsigned MAX_SAMPLES = wmsd_pkg::MaxSamplesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  wmsd_pkg::in_word_t            in_i,
  output logic                          result_valid_o,
  output wmsd_pkg::out_word_t           result_o,
  input  logic                          cfg_we_i,
  input  logic [wmsd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [wmsd_pkg::CfgW-1:0]     cfg_data_i
);

  localparam int unsigned AW   = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int unsigned CNTW = $clog2(MAX_SAMPLES + 1);
  localparam int unsigned CMPW = (CNTW > 12) ? CNTW : 12;
  localparam int unsigned SumW = wmsd_pkg::SumW;
  localparam int unsigned AccW = wmsd_pkg::AccW;
  localparam int unsigned DivW = wmsd_pkg::DivW;
  localparam int unsigned LenW = wmsd_pkg::LenW;
  localparam int unsigned IterW = wmsd_pkg::IterW;

  wmsd_pkg::state_e state_q, state_d;

  logic [wmsd_pkg::StartW-1:0] win_start_q;
  logic [LenW-1:0]             win_len_q;
  logic [CNTW-1:0]             cnt_q;
  logic                        ovf_q;
  logic                        win_ok_q;
  logic [LenW-1:0]             idx_q;
  logic                        rd_vld_q;
  logic                        sq_vld_q;
  logic [IterW-1:0]            it_q;

  logic [31:0]            mem_q [MAX_SAMPLES];
  logic [31:0]            rd_data_q;
  logic signed [SumW-1:0] sum_q;
  logic [AccW-1:0]        acc_q;
  logic [65:0]            sq_q;
  logic [DivW-1:0]        quo_q;
  logic [LenW-1:0]        rem_q;
  logic                   neg_q;
  logic [31:0]            mean_q;
  logic [63:0]            rad_q;
  logic [34:0]            srem_q;
  logic [31:0]            root_q;

  logic accept, full, win_ok, rd_en, pass_done, div_last, root_last;
  logic [CMPW-1:0] end_idx, rd_sum;
  logic [AW-1:0]   rd_addr;

  // divider step
  logic [LenW:0]   rem_sh, rem_sub;
  logic            div_ge;
  logic [LenW-1:0] rem_n;
  logic [DivW-1:0] quo_n;
  logic [SumW-1:0] sum_mag;
  logic [31:0]     mean_n;

  // square root step
  logic [34:0] srem_sh, trial, srem_n;
  logic        root_ge;

  // deviation
  logic signed [32:0] dev;
  logic [32:0]        dev_mag;

  assign accept   = start_i && (state_q == wmsd_pkg::S_IDLE);
  assign full     = (cnt_q == CNTW'(MAX_SAMPLES));
  assign end_idx  = CMPW'(win_start_q) + CMPW'(win_len_q);
  assign win_ok   = (win_len_q != '0) && (end_idx <= CMPW'(cnt_q));
  assign rd_en    = ((state_q == wmsd_pkg::S_SUM) || (state_q == wmsd_pkg::S_SQR)) &&
                    (idx_q != win_len_q);
  assign rd_sum   = CMPW'(win_start_q) + CMPW'(idx_q);
  assign rd_addr  = rd_sum[AW-1:0];
  assign pass_done = (idx_q == win_len_q) && !rd_vld_q && !sq_vld_q;
  assign div_last  = (it_q == IterW'(DivW - 1));
  assign root_last = (it_q == IterW'(31));

  assign rem_sh  = {rem_q, quo_q[DivW-1]};
  assign rem_sub = rem_sh - {1'b0, win_len_q};
  assign div_ge  = (rem_sh >= {1'b0, win_len_q});
  assign rem_n   = div_ge ? rem_sub[LenW-1:0] : rem_sh[LenW-1:0];
  assign quo_n   = {quo_q[DivW-2:0], div_ge};
  assign sum_mag = sum_q[SumW-1] ? SumW'(-sum_q) : SumW'(sum_q);
  assign mean_n  = neg_q ? (32'd0 - quo_n[31:0]) : quo_n[31:0];

  assign srem_sh = {srem_q[32:0], rad_q[63:62]};
  assign trial   = {1'b0, root_q, 2'b01};
  assign root_ge = (srem_sh >= trial);
  assign srem_n  = root_ge ? (srem_sh - trial) : srem_sh;

  assign dev     = 33'(signed'(rd_data_q)) - 33'(signed'(mean_q));
  assign dev_mag = dev[32] ? 33'(-dev) : 33'(dev);

  always_comb begin
    state_d = state_q;
    case (state_q)
      wmsd_pkg::S_IDLE:  if (accept && in_i.last_sample) state_d = wmsd_pkg::S_CHECK;
      wmsd_pkg::S_CHECK: state_d = win_ok ? wmsd_pkg::S_SUM : wmsd_pkg::S_DONE;
      wmsd_pkg::S_SUM:   if (pass_done) state_d = wmsd_pkg::S_MDIV;
      wmsd_pkg::S_MDIV:  if (div_last) state_d = wmsd_pkg::S_SQR;
      wmsd_pkg::S_SQR:   if (pass_done) state_d = wmsd_pkg::S_VDIV;
      wmsd_pkg::S_VDIV:  if (div_last) state_d = wmsd_pkg::S_ROOT;
      wmsd_pkg::S_ROOT:  if (root_last) state_d = wmsd_pkg::S_DONE;
      wmsd_pkg::S_DONE:  state_d = wmsd_pkg::S_IDLE;
      default:           state_d = wmsd_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wmsd_pkg::S_IDLE;
      win_start_q <= '0;
      win_len_q   <= '0;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      win_ok_q    <= 1'b0;
      idx_q       <= '0;
      rd_vld_q    <= 1'b0;
      sq_vld_q    <= 1'b0;
      it_q        <= '0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= rd_en;
      sq_vld_q <= rd_vld_q && (state_q == wmsd_pkg::S_SQR);
      if (cfg_we_i) begin
        case (cfg_idx_i)
          wmsd_pkg::CfgWinStart: win_start_q <= cfg_data_i[wmsd_pkg::StartW-1:0];
          wmsd_pkg::CfgWinLen:   win_len_q   <= cfg_data_i[LenW-1:0];
          default: ;
        endcase
      end
      if (accept) begin
        if (full) ovf_q <= 1'b1;
        else      cnt_q <= cnt_q + 1'b1;
      end
      if (state_q == wmsd_pkg::S_CHECK) win_ok_q <= win_ok;
      if (state_q == wmsd_pkg::S_DONE) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end
      if (rd_en) idx_q <= idx_q + 1'b1;
      else if ((state_q == wmsd_pkg::S_CHECK) || (state_q == wmsd_pkg::S_MDIV)) idx_q <= '0;
      if ((state_q == wmsd_pkg::S_MDIV) || (state_q == wmsd_pkg::S_VDIV))
        it_q <= div_last ? '0 : it_q + 1'b1;
      else if (state_q == wmsd_pkg::S_ROOT)
        it_q <= it_q + 1'b1;
      else
        it_q <= '0;
    end
  end

  // sample store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (accept && !full) mem_q[cnt_q[AW-1:0]] <= in_i.sample;
    rd_data_q <= mem_q[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      wmsd_pkg::S_CHECK: begin
        sum_q <= '0;
        acc_q <= '0;
      end
      wmsd_pkg::S_SUM: begin
        if (rd_vld_q) sum_q <= sum_q + SumW'(signed'(rd_data_q));
        if (pass_done) begin
          quo_q <= DivW'(sum_mag);
          rem_q <= '0;
          neg_q <= sum_q[SumW-1];
        end
      end
      wmsd_pkg::S_MDIV: begin
        quo_q <= quo_n;
        rem_q <= rem_n;
        if (div_last) mean_q <= mean_n;
      end
      wmsd_pkg::S_SQR: begin
        if (rd_vld_q) sq_q <= 66'(dev_mag) * 66'(dev_mag);
        if (sq_vld_q) acc_q <= acc_q + AccW'(sq_q);
        if (pass_done) begin
          quo_q <= DivW'(acc_q);
          rem_q <= '0;
        end
      end
      wmsd_pkg::S_VDIV: begin
        quo_q <= quo_n;
        rem_q <= rem_n;
        if (div_last) begin
          rad_q  <= quo_n[63:0];
          srem_q <= '0;
          root_q <= '0;
        end
      end
      wmsd_pkg::S_ROOT: begin
        srem_q <= srem_n;
        root_q <= {root_q[30:0], root_ge};
        rad_q  <= {rad_q[61:0], 2'b00};
      end
      default: ;
    endcase
  end

  assign busy_o         = (state_q != wmsd_pkg::S_IDLE);
  assign result_valid_o = (state_q == wmsd_pkg::S_DONE);

  always_comb begin
    result_o.mean           = win_ok_q ? signed'(mean_q) : '0;
    result_o.std_dev        = win_ok_q ? root_q : '0;
    result_o.window_valid   = win_ok_q;
    result_o.store_overflow = ovf_q;
  end

endmodule

// File: sv/wmsd_checker.sv
// Port-level checks for windowed_mean_std_dev_unit, bound to the top level.
// Depends on wmsd_pkg.
module wmsd_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         start_i,
  input logic                         busy_o,
  input wmsd_pkg::in_word_t           in_i,
  input logic                         result_valid_o,
  input wmsd_pkg::out_word_t          result_o
);

  // a result only comes out of the compute sequence
  a_res_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy_o) else $error("result without busy");

  a_res_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o) else $error("result strobe longer than one cycle");

  a_bad_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.window_valid) |->
      (result_o.mean == '0 && result_o.std_dev == '0))
    else $error("invalid window with nonzero fields");

  // plain load words never stall the stream
  a_load_rate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && !in_i.last_sample) |=> !busy_o)
    else $error("busy after plain load word");

  a_last_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && in_i.last_sample) |=> busy_o)
    else $error("last word did not start computation");

endmodule

bind windowed_mean_std_dev_unit wmsd_checker u_wmsd_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .in_i           (in_i),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
